### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the TCP option parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed: invariant");
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/tcpopt_pkg.sv
// Types and constants of the TCP option parser.
`timescale 1ns / 1ps
package tcpopt_pkg;

    localparam logic [7:0] KIND_EOL   = 8'd0;
    localparam logic [7:0] KIND_NOP   = 8'd1;
    localparam logic [7:0] KIND_MSS   = 8'd2;
    localparam logic [7:0] KIND_WIN   = 8'd3;
    localparam logic [7:0] KIND_SACKP = 8'd4;
    localparam logic [7:0] KIND_TIME  = 8'd8;

    localparam logic [7:0] LEN_MSS  = 8'd4;
    localparam logic [7:0] LEN_WIN  = 8'd3;
    localparam logic [7:0] LEN_TIME = 8'd10;
    localparam logic [7:0] LEN_MIN  = 8'd2;

    localparam logic [5:0] POS_KIND   = 6'd0;
    localparam logic [5:0] POS_LENGTH = 6'd1;
    localparam logic [5:0] POS_DATA   = 6'd2;
    localparam logic [5:0] POS_ECHO   = 6'd6;

    typedef struct packed {
        logic [5:0]  pos;
        logic [7:0]  kind;
        logic [7:0]  length;
        logic        stopped;
        logic [15:0] mss;
        logic [7:0]  wscale;
        logic        sack;
        logic [31:0] ts;
        logic [31:0] ts_echo;
        logic [5:0]  nop;
        logic [5:0]  eol;
    } t_parse_state;

    typedef struct packed {
        logic [15:0] mss;
        logic [7:0]  wscale;
        logic        sack_permitted;
        logic [31:0] timestamp;
        logic [31:0] ts_reply;
        logic [5:0]  nop_seen;
        logic [5:0]  eol_seen;
    } t_result;

endpackage

### hw/rtl/tcpopt_step.sv
// Next-state and result logic for one option byte of the TCP option parser.
`timescale 1ns / 1ps
module tcpopt_step (
    input  tcpopt_pkg::t_parse_state i_state,
    input  logic [7:0]               i_opt_byte,
    input  logic [5:0]               i_bytes_left,
    output tcpopt_pkg::t_parse_state o_state,
    output logic                     o_emit,
    output tcpopt_pkg::t_result      o_result
);
    import tcpopt_pkg::*;

    t_parse_state s;
    logic [7:0]   left_plus1;
    logic [8:0]   pos_plus1;

    always_comb begin
        s          = i_state;
        left_plus1 = {2'b00, i_bytes_left} + 8'd1;
        pos_plus1  = {3'b000, i_state.pos} + 9'd1;

        if (i_bytes_left != 6'd0 && !i_state.stopped) begin
            if (i_state.pos == POS_KIND) begin
                if (i_opt_byte == KIND_NOP) begin
                    s.nop = i_state.nop + 6'd1;
                end else if (i_opt_byte == KIND_EOL) begin
                    s.eol = i_state.eol + 6'd1;
                end else if (i_bytes_left >= 6'd2) begin
                    s.kind = i_opt_byte;
                    s.pos  = POS_LENGTH;
                end else begin
                    s.stopped = 1'b1;
                end
            end else if (i_state.pos == POS_LENGTH) begin
                // The length counts from the kind byte, one beat back.
                if (i_opt_byte < LEN_MIN || left_plus1 < i_opt_byte) begin
                    s.stopped = 1'b1;
                    s.pos     = POS_KIND;
                end else begin
                    s.length = i_opt_byte;
                    if (i_state.kind == KIND_SACKP) begin
                        s.sack = 1'b1;
                    end
                    s.pos = (i_opt_byte == LEN_MIN) ? POS_KIND : POS_DATA;
                end
            end else begin
                if (i_state.kind == KIND_MSS && i_state.length == LEN_MSS) begin
                    s.mss = {i_state.mss[7:0], i_opt_byte};
                end else if (i_state.kind == KIND_WIN && i_state.length == LEN_WIN) begin
                    if (i_state.pos == POS_DATA) begin
                        s.wscale = i_opt_byte;
                    end
                end else if (i_state.kind == KIND_TIME && i_state.length == LEN_TIME) begin
                    if (i_state.pos < POS_ECHO) begin
                        s.ts = {i_state.ts[23:0], i_opt_byte};
                    end else begin
                        s.ts_echo = {i_state.ts_echo[23:0], i_opt_byte};
                    end
                end
                if (pos_plus1 >= {1'b0, i_state.length}) begin
                    s.pos = POS_KIND;
                end else begin
                    s.pos = pos_plus1[5:0];
                end
            end
        end

        o_emit                  = (i_bytes_left <= 6'd1);
        o_result.mss            = s.mss;
        o_result.wscale         = s.wscale;
        o_result.sack_permitted = s.sack;
        o_result.timestamp      = s.ts;
        o_result.ts_reply       = s.ts_echo;
        o_result.nop_seen       = s.nop;
        o_result.eol_seen       = s.eol;
        o_state                 = o_emit ? '0 : s;
    end

endmodule

### hw/rtl/tcpopt_out_reg.sv
// Result register of the TCP option parser, holding one result beat.
`timescale 1ns / 1ps
module tcpopt_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tcpopt_pkg::t_result i_result,
    input  logic                i_ready,
    output logic                o_valid,
    output tcpopt_pkg::t_result o_result
);
    import tcpopt_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### hw/rtl/tcp_option_parser.sv
// Top level of the TCP option parser: input register, parse state and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// The block walks the TCP options area one byte per beat. Each input beat
// carries one option byte and the count of option bytes left, this one
// included; a count of zero marks an empty area and its byte is ignored.
// Both channels use valid and ready. A beat is taken into the input
// register, and the parse logic updates the running state from that
// byte when the beat advances. On the last byte of an area, or on an
// empty area, the collected fields go to the result register and the
// parse state returns to zero, so the next area starts clean. The input
// register and the result register lie between a byte and its result.
// Throughput is one byte per cycle while no result waits on the receiver.
// When the receiver stalls, a waiting result holds in the result register;
// bytes that produce no result keep flowing, and only a byte that would
// produce a second result waits in the input register, which then holds
// the input channel ready low.
// Reset clears the parse state and both valid flags; no beat is lost or
// created by reset beyond those in flight.
module tcp_option_parser #(
    parameter int MAX_OPTION_BYTES = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_opt_byte,
    input  logic [5:0]  i_bytes_left,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_mss,
    output logic [7:0]  o_wscale,
    output logic        o_sack_permitted,
    output logic [31:0] o_timestamp,
    output logic [31:0] o_ts_reply,
    output logic [5:0]  o_nop_seen,
    output logic [5:0]  o_eol_seen
);
    import tcpopt_pkg::*;

    localparam logic [5:0] MaxLeft = 6'(MAX_OPTION_BYTES);

    logic         r_in_valid;
    logic         n_in_valid;
    logic [7:0]   r_byte;
    logic [5:0]   r_left;
    logic [5:0]   left_sat;
    logic [13:0]  in_beat;
    t_parse_state r_state;
    t_parse_state step_state;
    logic         step_emit;
    t_result      step_result;
    t_result      out_result;
    logic         adv;
    logic         take;

    assign left_sat = (i_bytes_left > MaxLeft) ? MaxLeft : i_bytes_left;
    assign in_beat  = {r_byte, r_left};

    tcpopt_step u_step (
        .i_state      (r_state),
        .i_opt_byte   (r_byte),
        .i_bytes_left (r_left),
        .o_state      (step_state),
        .o_emit       (step_emit),
        .o_result     (step_result)
    );

    assign adv        = r_in_valid && (!step_emit || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        if (take) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (adv) begin
                r_state <= step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_opt_byte;
            r_left <= left_sat;
        end
    end

    tcpopt_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && step_emit),
        .i_result (step_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_mss            = out_result.mss;
    assign o_wscale         = out_result.wscale;
    assign o_sack_permitted = out_result.sack_permitted;
    assign o_timestamp      = out_result.timestamp;
    assign o_ts_reply       = out_result.ts_reply;
    assign o_nop_seen       = out_result.nop_seen;
    assign o_eol_seen       = out_result.eol_seen;

    `ASSERT_NEXT(a_state_cleared, i_clk, i_rst_n, adv && step_emit, r_state == '0)
    `ASSERT_ALWAYS(a_stop_at_kind, i_clk, i_rst_n, !r_state.stopped || r_state.pos == POS_KIND)
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(in_beat))
    `ASSERT_IMPL(a_out_from_stage, i_clk, i_rst_n, $rose(o_out_valid), $past(adv && step_emit))

endmodule

### tb/sv/tcp_option_parser_tb.sv
// Self-checking testbench for tcp_option_parser with directed and random option areas.
`timescale 1ns / 1ps

module tcp_option_parser_tb;
    import tcpopt_pkg::*;

    localparam int MAX_BYTES    = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_opt_byte;
    logic [5:0]  i_bytes_left;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_mss;
    logic [7:0]  o_wscale;
    logic        o_sack_permitted;
    logic [31:0] o_timestamp;
    logic [31:0] o_ts_reply;
    logic [5:0]  o_nop_seen;
    logic [5:0]  o_eol_seen;

    logic [5:0]  walk_pos;
    logic [7:0]  walk_kind;
    logic [7:0]  walk_len;
    logic        walk_halted;
    t_result     found;

    t_result     expected_results[$];
    logic [7:0]  area_bytes[$];
    logic [7:0]  record_bytes[$];
    int          sent_bytes;
    int          results_seen;
    int          mismatches;
    int          cycle_count;
    bit          calm;

    tcp_option_parser #(
        .MAX_OPTION_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opt_byte       (i_opt_byte),
        .i_bytes_left     (i_bytes_left),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mss            (o_mss),
        .o_wscale         (o_wscale),
        .o_sack_permitted (o_sack_permitted),
        .o_timestamp      (o_timestamp),
        .o_ts_reply       (o_ts_reply),
        .o_nop_seen       (o_nop_seen),
        .o_eol_seen       (o_eol_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void clear_walk();
        walk_pos    = POS_KIND;
        walk_kind   = '0;
        walk_len    = '0;
        walk_halted = 1'b0;
        found       = '0;
    endfunction

    function automatic void parse_byte(logic [7:0] b, int left);
        if (walk_halted) return;
        if (walk_pos == POS_KIND) begin
            if (b == KIND_NOP) begin
                found.nop_seen = found.nop_seen + 6'd1;
            end else if (b == KIND_EOL) begin
                found.eol_seen = found.eol_seen + 6'd1;
            end else if (left >= 2) begin
                walk_kind = b;
                walk_pos  = POS_LENGTH;
            end else begin
                walk_halted = 1'b1;
            end
            return;
        end
        if (walk_pos == POS_LENGTH) begin
            if (b < LEN_MIN || left + 1 < int'(b)) begin
                walk_halted = 1'b1;
                walk_pos    = POS_KIND;
                return;
            end
            walk_len = b;
            if (walk_kind == KIND_SACKP) found.sack_permitted = 1'b1;
            walk_pos = (b == LEN_MIN) ? POS_KIND : POS_DATA;
            return;
        end
        if (walk_kind == KIND_MSS && walk_len == LEN_MSS) begin
            found.mss = {found.mss[7:0], b};
        end else if (walk_kind == KIND_WIN && walk_len == LEN_WIN) begin
            if (walk_pos == POS_DATA) found.wscale = b;
        end else if (walk_kind == KIND_TIME && walk_len == LEN_TIME) begin
            if (walk_pos < POS_ECHO) found.timestamp = {found.timestamp[23:0], b};
            else found.ts_reply = {found.ts_reply[23:0], b};
        end
        if (int'(walk_pos) + 1 >= int'(walk_len)) walk_pos = POS_KIND;
        else walk_pos = walk_pos + 6'd1;
    endfunction

    function automatic void predict_options(logic [7:0] b, logic [5:0] left_raw);
        int left;
        left = (left_raw > MAX_BYTES) ? MAX_BYTES : int'(left_raw);
        if (left != 0) begin
            parse_byte(b, left);
        end
        if (left <= 1) begin
            expected_results.push_back(found);
            clear_walk();
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s expected 0x%0h got 0x%0h",
                                      results_seen, name, want, got));
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          results_seen));
            end else begin
                want = expected_results.pop_front();
                compare_field("mss", 32'(want.mss), 32'(o_mss));
                compare_field("wscale", 32'(want.wscale), 32'(o_wscale));
                compare_field("sack_permitted", 32'(want.sack_permitted),
                              32'(o_sack_permitted));
                compare_field("timestamp", want.timestamp, o_timestamp);
                compare_field("ts_reply", want.ts_reply, o_ts_reply);
                compare_field("nop_seen", 32'(want.nop_seen), 32'(o_nop_seen));
                compare_field("eol_seen", 32'(want.eol_seen), 32'(o_eol_seen));
            end
            results_seen++;
        end
        i_out_ready <= calm || ($urandom_range(0, 99) >= 22);
    end

    task automatic send_byte(logic [7:0] b, logic [5:0] left);
        if (!calm && $urandom_range(0, 99) < 11) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opt_byte   <= b;
        i_bytes_left <= left;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_bytes++;
        predict_options(b, left);
    endtask

    task automatic send_area();
        int n;
        n = area_bytes.size();
        for (int i = 0; i < n; i++) send_byte(area_bytes[i], 6'(n - i));
    endtask

    function automatic int pick_len(int usual, int lo, int hi);
        return ($urandom_range(0, 99) < 80) ? usual : int'($urandom_range(lo, hi));
    endfunction

    function automatic void build_record();
        logic [7:0] kind;
        int         len;
        record_bytes.delete();
        len = 0;
        case ($urandom_range(0, 7))
            0: kind = KIND_NOP;
            1: kind = KIND_EOL;
            2: begin
                kind = KIND_MSS;
                len  = pick_len(int'(LEN_MSS), 2, 6);
            end
            3: begin
                kind = KIND_WIN;
                len  = pick_len(int'(LEN_WIN), 2, 5);
            end
            4: begin
                kind = KIND_SACKP;
                len  = pick_len(int'(LEN_MIN), 2, 4);
            end
            5, 6: begin
                kind = KIND_TIME;
                len  = pick_len(int'(LEN_TIME), 2, 12);
            end
            default: begin
                kind = 8'($urandom_range(5, 255));
                if (kind == KIND_TIME) kind = KIND_TIME + 8'd1;
                len = int'($urandom_range(2, 8));
            end
        endcase
        record_bytes.push_back(kind);
        if (len != 0) begin
            record_bytes.push_back(8'(len));
            for (int i = 2; i < len; i++) record_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void build_area(int target);
        area_bytes.delete();
        while (area_bytes.size() < target) begin
            build_record();
            if (area_bytes.size() + record_bytes.size() <= target) begin
                foreach (record_bytes[i]) area_bytes.push_back(record_bytes[i]);
            end else begin
                area_bytes.push_back($urandom_range(0, 1) ? KIND_NOP : KIND_EOL);
            end
        end
    endfunction

    task automatic test_empty_area();
        send_byte(8'hFF, 6'd0);
    endtask

    task automatic test_every_kind();
        area_bytes = {KIND_MSS, LEN_MSS, 8'hFF, 8'hFF, KIND_WIN, LEN_WIN, 8'hFF,
                      KIND_SACKP, LEN_MIN, KIND_NOP, KIND_EOL};
        send_area();
    endtask

    task automatic test_timestamp_extremes();
        area_bytes = {KIND_TIME, LEN_TIME, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'h00, 8'h00};
        send_area();
    endtask

    task automatic test_walk_stops();
        send_byte(KIND_NOP, 6'd63);
        send_byte(KIND_MSS, 6'd39);
        send_byte(8'd1, 6'd38);
        send_byte(8'hFF, 6'd0);
    endtask

    task automatic test_kind_as_last_byte();
        send_byte(KIND_WIN, 6'd2);
        send_byte(LEN_WIN, 6'd1);
        send_byte(KIND_TIME, 6'd1);
    endtask

    task automatic test_random_areas(int count);
        int goal;
        int mode;
        int n;
        int cut;
        goal = sent_bytes + count;
        while (sent_bytes < goal) begin
            mode = $urandom_range(0, 99);
            build_area($urandom_range(1, MAX_BYTES));
            n = area_bytes.size();
            if (mode < 70) begin
                send_area();
            end else if (mode < 78) begin
                cut = $urandom_range(1, n);
                area_bytes = area_bytes[0:cut-1];
                send_area();
            end else if (mode < 84) begin
                cut = $urandom_range(0, n - 1);
                for (int i = 0; i < cut; i++) send_byte(area_bytes[i], 6'(n - i));
                send_byte(8'($urandom_range(0, 255)), 6'd0);
            end else if (mode < 90) begin
                send_byte(area_bytes[0], 6'($urandom_range(MAX_BYTES + 1, 63)));
                for (int i = 1; i < n; i++) send_byte(area_bytes[i], 6'(n - i));
            end else if (mode < 95) begin
                for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 6'(n - i));
            end else begin
                cut = $urandom_range(1, 12);
                for (int i = 0; i < cut; i++) begin
                    send_byte(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
                end
            end
        end
        send_byte(8'($urandom_range(0, 255)), 6'd0);
    endtask

    task automatic test_back_to_back(int count);
        int goal;
        goal = sent_bytes + count;
        calm = 1'b1;
        while (sent_bytes < goal) begin
            build_area($urandom_range(1, MAX_BYTES));
            send_area();
        end
        calm = 1'b0;
    endtask

    initial begin
        clear_walk();
        sent_bytes   = 0;
        results_seen = 0;
        mismatches   = 0;
        cycle_count  = 0;
        calm         = 1'b0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_opt_byte   <= '0;
        i_bytes_left <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_area();
        test_every_kind();
        test_timestamp_extremes();
        test_walk_stops();
        test_kind_as_last_byte();
        test_random_areas(700);
        test_back_to_back(200);
        test_random_areas(650);

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
